>>> rtl/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types, constants and helpers of the vertex camera projection block.
// ----------------------------------------------------------------------------
package vcp_pkg;

  localparam int DIV_STEPS = 32;

  localparam logic signed [31:0] Z_EPS     = 32'sd6554;
  localparam logic        [31:0] SAT_MAG   = 32'd512;   // 2^40/512 = 2^31
  localparam logic        [32:0] REM_START = 33'd256;   // 2^40 >> 32
  localparam logic        [23:0] INT24_MAX = 24'hFFFFFF;
  localparam logic        [23:0] HAZE_MAX  = 24'hFF0000;

  // Register indexes
  localparam logic [2:0] REG_MCOL_X = 3'd0;
  localparam logic [2:0] REG_MCOL_Y = 3'd1;
  localparam logic [2:0] REG_MCOL_Z = 3'd2;
  localparam logic [2:0] REG_TXY    = 3'd3;
  localparam logic [2:0] REG_TZV    = 3'd4;
  localparam logic [2:0] REG_CENTER = 3'd5;
  localparam logic [2:0] REG_STARTS = 3'd6;
  localparam logic [2:0] REG_MODE   = 3'd7;

  // Per-vertex data carried alongside the reciprocal and projection stages
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic        [23:0] inten;
    logic               last;
  } vtx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

>>> rtl/vertex_camera_projection.sv
// ----------------------------------------------------------------------------
// vertex_camera_projection
// Camera transform, reciprocal depth and perspective projection of vertices.
// ----------------------------------------------------------------------------
// Pipeline of 2 transform, 34 divider, 4 projection stages. Throughput: one
// vertex per clock while the output is not stalled; the
// 32-stage restoring divider for 1/z sets the depth.
// Reset clears all valid bits and the configuration registers; a stall on the
// output freezes the whole pipeline, so nothing is lost or repeated.
// Invisible vertices are transferred in but produce no result.
module vertex_camera_projection (
  input  logic               clk,
  input  logic               rst,
  // vertex input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic               point_visible,
  input  logic        [23:0] intensity_in,
  input  logic               last_vertex,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] cam_x,
  output logic signed [31:0] cam_y,
  output logic signed [31:0] cam_z,
  output logic signed [31:0] inv_z,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic        [23:0] intensity_out,
  output logic        [23:0] haze_value,
  output logic               last_out,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [63:0] cfg_data
);
  import vcp_pkg::*;

  // configuration registers
  logic [63:0] mcol_x, mcol_y, mcol_z, txy, tzv, center, starts;
  logic [9:0]  mode;

  // pipeline control: the whole pipe moves unless a held result is stalled
  logic en;

  logic        v1, v2;
  logic [23:0] inten1, inten2;
  logic        last1, last2;
  logic signed [31:0] cx, cy, cz_raw;
  vtx_t        tdata;

  logic        rv;
  vtx_t        rdata;
  logic signed [31:0] riz;

  vtx_t        pdata;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mcol_x <= '0; mcol_y <= '0; mcol_z <= '0; txy <= '0;
      tzv <= '0; center <= '0; starts <= '0; mode <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MCOL_X: mcol_x <= cfg_data;
        REG_MCOL_Y: mcol_y <= cfg_data;
        REG_MCOL_Z: mcol_z <= cfg_data;
        REG_TXY:    txy    <= cfg_data;
        REG_TZV:    tzv    <= cfg_data;
        REG_CENTER: center <= cfg_data;
        REG_STARTS: starts <= cfg_data;
        REG_MODE:   mode   <= cfg_data[9:0];
        default:    ;
      endcase
    end
  end

  // matrix columns
  vcp_transform u_tx (
    .clk(clk), .en(en), .wx(world_x), .wy(world_y), .wz(world_z),
    .col(mcol_x), .t($signed(txy[31:0])), .c(cx)
  );
  vcp_transform u_ty (
    .clk(clk), .en(en), .wx(world_x), .wy(world_y), .wz(world_z),
    .col(mcol_y), .t($signed(txy[63:32])), .c(cy)
  );
  vcp_transform u_tz (
    .clk(clk), .en(en), .wx(world_x), .wy(world_y), .wz(world_z),
    .col(mcol_z), .t($signed(tzv[31:0])), .c(cz_raw)
  );

  // side data alongside the transform; invisible vertices enter as bubbles
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && point_visible;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inten1 <= intensity_in; last1 <= last_vertex;
      inten2 <= inten1;       last2 <= last1;
    end
  end

  // zero depth becomes 0.1 before any later use
  always_comb begin
    tdata.cx    = cx;
    tdata.cy    = cy;
    tdata.cz    = (cz_raw == 32'sd0) ? Z_EPS : cz_raw;
    tdata.inten = inten2;
    tdata.last  = last2;
  end

  vcp_recip u_recip (
    .clk(clk), .rst(rst), .en(en), .v_in(v2), .d_in(tdata),
    .v_out(rv), .d_out(rdata), .iz(riz)
  );

  vcp_project u_proj (
    .clk(clk), .rst(rst), .en(en), .v_in(rv), .d_in(rdata), .iz_in(riz),
    .view($signed(tzv[63:32])),
    .center_x($signed(center[31:0])), .center_y($signed(center[63:32])),
    .cue_start($signed(starts[31:0])), .haze_start($signed(starts[63:32])),
    .mode(mode),
    .v_out(out_valid), .d_out(pdata), .iz_out(inv_z),
    .sx(screen_x), .sy(screen_y), .inten_out(intensity_out), .haze_out(haze_value)
  );

  assign cam_x    = pdata.cx;
  assign cam_y    = pdata.cy;
  assign cam_z    = pdata.cz;
  assign last_out = pdata.last;

endmodule

>>> rtl/vcp_transform.sv
// ----------------------------------------------------------------------------
// vcp_transform
// One column of the affine camera matrix: three products, then sum and offset.
// ----------------------------------------------------------------------------
module vcp_transform (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] wx,
  input  logic signed [31:0] wy,
  input  logic signed [31:0] wz,
  input  logic        [63:0] col,
  input  logic signed [31:0] t,
  output logic signed [31:0] c
);
  import vcp_pkg::*;

  logic signed [20:0] k0, k1, k2;
  logic signed [52:0] p0, p1, p2;
  logic signed [54:0] acc;
  logic signed [54:0] acc_sh;

  assign k0 = $signed(col[20:0]);
  assign k1 = $signed(col[41:21]);
  assign k2 = $signed(col[62:42]);

  assign acc    = 55'(p0) + 55'(p1) + 55'(p2);
  assign acc_sh = acc >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= wx * k0;
      p1 <= wy * k1;
      p2 <= wz * k2;
      c  <= sat32(64'(acc_sh) + 64'(t));
    end
  end

endmodule

>>> rtl/vcp_recip.sv
// ----------------------------------------------------------------------------
// vcp_recip
// Pipelined restoring divider giving 2^40 / cz, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vcp_recip (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  vcp_pkg::vtx_t      d_in,
  output logic               v_out,
  output vcp_pkg::vtx_t      d_out,
  output logic signed [31:0] iz
);
  import vcp_pkg::*;

  logic        v    [DIV_STEPS+1];
  vtx_t        d    [DIV_STEPS+1];
  logic [31:0] mag  [DIV_STEPS+1];
  logic [31:0] rem  [DIV_STEPS+1];
  logic [31:0] q    [DIV_STEPS+1];
  logic        neg  [DIV_STEPS+1];
  logic        sat  [DIV_STEPS+1];

  logic [31:0] rem_next [DIV_STEPS];
  logic [31:0] q_next   [DIV_STEPS];
  logic [31:0] in_mag;
  logic        in_neg;

  assign in_neg = d_in.cz[31];
  assign in_mag = in_neg ? 32'(-d_in.cz) : d_in.cz;

  always_comb begin
    logic [32:0] sh;
    logic        ge;
    for (int s = 0; s < DIV_STEPS; s++) begin
      sh          = {rem[s], 1'b0};
      ge          = sh >= {1'b0, mag[s]};
      rem_next[s] = ge ? 32'(sh - {1'b0, mag[s]}) : sh[31:0];
      q_next[s]   = {q[s][30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STEPS; s++) v[s] <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v[0] <= v_in;
      for (int s = 0; s < DIV_STEPS; s++) v[s+1] <= v[s];
      v_out <= v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0]   <= d_in;
      mag[0] <= in_mag;
      rem[0] <= REM_START[31:0];
      q[0]   <= '0;
      neg[0] <= in_neg;
      sat[0] <= in_mag <= SAT_MAG;
      for (int s = 0; s < DIV_STEPS; s++) begin
        d[s+1]   <= d[s];
        mag[s+1] <= mag[s];
        rem[s+1] <= rem_next[s];
        q[s+1]   <= q_next[s];
        neg[s+1] <= neg[s];
        sat[s+1] <= sat[s];
      end
      d_out <= d[DIV_STEPS];
      if (neg[DIV_STEPS])
        iz <= sat[DIV_STEPS] ? -32'sh8000_0000 : -$signed(q[DIV_STEPS]);
      else
        iz <= sat[DIV_STEPS] ? 32'sh7FFF_FFFF : $signed(q[DIV_STEPS]);
    end
  end

endmodule

>>> rtl/vcp_project.sv
// ----------------------------------------------------------------------------
// vcp_project
// Screen projection, depth cueing and haze from camera position and 1/z.
// ----------------------------------------------------------------------------
module vcp_project (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  vcp_pkg::vtx_t      d_in,
  input  logic signed [31:0] iz_in,
  input  logic signed [31:0] view,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] cue_start,
  input  logic signed [31:0] haze_start,
  input  logic        [9:0]  mode,
  output logic               v_out,
  output vcp_pkg::vtx_t      d_out,
  output logic signed [31:0] iz_out,
  output logic signed [31:0] sx,
  output logic signed [31:0] sy,
  output logic        [23:0] inten_out,
  output logic        [23:0] haze_out
);
  import vcp_pkg::*;

  logic        [7:0]  levels;
  // stage 1
  logic               v1, cue1, hon1, far1;
  vtx_t               d1;
  logic signed [31:0] iz1;
  logic signed [63:0] pk1, pr1, ph1;
  // stage 2
  logic               v2, cue2, hon2, far2;
  vtx_t               d2;
  logic signed [31:0] iz2, k2, r2, h2;
  // stage 3
  logic               v3, cue3, hon3, far3;
  vtx_t               d3;
  logic signed [31:0] iz3;
  logic signed [63:0] pkx3, pky3, pi3, ph3;
  // final stage logic
  logic signed [63:0] ksh_x, ksh_y, ish;

  assign levels = mode[9:2];
  assign ksh_x  = pkx3 >>> 16;
  assign ksh_y  = pky3 >>> 16;
  assign ish    = pi3 >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v_out <= 1'b0;
    end else if (en) begin
      v1 <= v_in; v2 <= v1; v3 <= v2; v_out <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= d_in;
      iz1  <= iz_in;
      cue1 <= mode[0] && (d_in.cz > cue_start);
      hon1 <= mode[1];
      far1 <= d_in.cz > haze_start;
      pk1  <= view * iz_in;
      pr1  <= cue_start * iz_in;
      ph1  <= haze_start * iz_in;

      d2 <= d1; iz2 <= iz1; cue2 <= cue1; hon2 <= hon1; far2 <= far1;
      k2 <= sat32(pk1 >>> 24);
      r2 <= sat32(pr1 >>> 24);
      h2 <= sat32(ph1 >>> 24);

      d3 <= d2; iz3 <= iz2; cue3 <= cue2; hon3 <= hon2; far3 <= far2;
      pkx3 <= k2 * d2.cx;
      pky3 <= k2 * d2.cy;
      pi3  <= $signed({1'b0, d2.inten}) * r2;
      ph3  <= h2 * $signed({1'b0, levels});

      d_out  <= d3;
      iz_out <= iz3;
      sx <= sat32(ksh_x + 64'(center_x));
      sy <= sat32(64'(center_y) - ksh_y);
      if (!cue3)                            inten_out <= d3.inten;
      else if (ish < 0)                     inten_out <= '0;
      else if (ish > 64'(INT24_MAX))        inten_out <= INT24_MAX;
      else                                  inten_out <= ish[23:0];
      if (!hon3)                            haze_out <= '0;
      else if (!far3)                       haze_out <= {levels, 16'h0000};
      else if (ph3 < 0)                     haze_out <= '0;
      else if (ph3 > 64'(HAZE_MAX))         haze_out <= HAZE_MAX;
      else                                  haze_out <= ph3[23:0];
    end
  end

endmodule
